[design/ccnc_pkg.sv]
// ----------------------------------------------------------------------------
// Capacity-constrained nearest center: shared package
// Widths, request and register codes, the center record type, and the
// helper that clamps the active cluster count.
// ----------------------------------------------------------------------------
package ccnc_pkg;

    // Number of center slots and the widths that follow from it.
    localparam int MAX_CLUSTERS = 16;
    localparam int IDX_W        = $clog2(MAX_CLUSTERS);
    localparam int CNT_W        = $clog2(MAX_CLUSTERS + 1);

    // Field widths.
    localparam int REQ_W   = 2;
    localparam int SLOT_W  = 4;
    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * COORD_W + 1;
    localparam int DIST_W  = 50;
    localparam int CC_W    = 5;
    localparam int PC_W    = 16;
    localparam int FILL_W  = 16;

    // Stream and configuration port widths.
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 56;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ASSIGN = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT   = 2'd1;

    // One stored center.
    typedef struct packed {
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } center_t;

    // Clamp the programmed cluster count to 1..MAX_CLUSTERS.
    function automatic logic [CNT_W-1:0] active_count(input logic [CC_W-1:0] cc);
        logic [CNT_W-1:0] n;
        if (cc == '0) begin
            n = CNT_W'(1);
        end else if (int'(cc) > MAX_CLUSTERS) begin
            n = CNT_W'(MAX_CLUSTERS);
        end else begin
            n = CNT_W'(cc);
        end
        return n;
    endfunction

endpackage

[design/ccnc_div.sv]
// ----------------------------------------------------------------------------
// Capacity divider
// Restoring divider, one quotient bit per cycle, that works out
// point_count divided by the active cluster count.
// ----------------------------------------------------------------------------
module ccnc_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ccnc_pkg::PC_W-1:0]   dividend,
    input  logic [ccnc_pkg::CNT_W-1:0]  divisor,
    output logic                        busy,
    output logic [ccnc_pkg::PC_W-1:0]   quotient
);
    import ccnc_pkg::*;

    localparam int STEP_W = $clog2(PC_W + 1);

    logic                busy_reg,  busy_next;
    logic [STEP_W-1:0]   step_reg,  step_next;
    logic [CNT_W-1:0]    rem_reg,   rem_next;
    logic [PC_W-1:0]     quot_reg,  quot_next;
    logic [CNT_W-1:0]    dvsr_reg,  dvsr_next;
    logic [CNT_W:0]      trial;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvsr_next = dvsr_reg;
        trial     = {rem_reg, quot_reg[PC_W-1]};
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quot_next = dividend;
            dvsr_next = divisor;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvsr_reg}) begin
                rem_next  = CNT_W'(trial - {1'b0, dvsr_reg});
                quot_next = {quot_reg[PC_W-2:0], 1'b1};
            end else begin
                rem_next  = trial[CNT_W-1:0];
                quot_next = {quot_reg[PC_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(PC_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    // The quotient register holds the capacity, one after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            quot_reg <= PC_W'(1);
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            quot_reg <= quot_next;
        end
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quot_reg;

endmodule

[design/capacity_constrained_nearest_center_top.sv]
// ----------------------------------------------------------------------------
// Capacity-constrained nearest center
// Assigns 3-D points to the nearest stored center that still has room.
// ----------------------------------------------------------------------------
// An assign-point request walks the active centers one per cycle through a
// single shared difference, square, sum and compare pipeline, and the input
// is not ready from the accepting transfer until the result is offered. A
// configuration write restarts the capacity divider, which loads its operands
// and then produces one quotient bit per cycle; no input transfer is taken
// until it is done.
module capacity_constrained_nearest_center_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ccnc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ccnc_pkg::CFG_DAT_W-1:0]     cfg_data,
    // Request stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: center_slot[3:0], pos_x[27:4], pos_y[51:28], pos_z[75:52], zero pad.
    input  logic [ccnc_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: req_type[1:0].
    input  logic [ccnc_pkg::REQ_W-1:0]         s_tuser,
    // Result stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: cluster_index[3:0], sq_distance[53:4], zero pad.
    output logic [ccnc_pkg::M_TDATA_W-1:0]     m_tdata,
    // m_tuser: no_room[0].
    output logic                               m_tuser
);
    import ccnc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Configuration and capacity.
    logic [CC_W-1:0]   cluster_count_reg;
    logic [PC_W-1:0]   point_count_reg;
    logic              div_start_reg;
    logic              div_busy;
    logic [PC_W-1:0]   capacity;
    logic [CNT_W-1:0]  n_act;

    // Sequencer and stored state.
    logic [1:0]                  state_reg;
    logic [CNT_W-1:0]            cnt_reg;
    center_t                     center_mem [MAX_CLUSTERS];
    logic [FILL_W-1:0]           fill_reg   [MAX_CLUSTERS];
    logic signed [COORD_W-1:0]   px_reg, py_reg, pz_reg;

    // Pipeline stages.
    logic                        v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IDX_W-1:0]            idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic                        el1_reg, el2_reg, el3_reg, el4_reg;
    center_t                     c1_reg;
    logic signed [DIFF_W-1:0]    dx2_reg, dy2_reg, dz2_reg;
    logic signed [2*DIFF_W-1:0]  sqx, sqy, sqz;
    logic [SQ_W-1:0]             sx3_reg, sy3_reg, sz3_reg;
    logic [DIST_W-1:0]           sum4_reg;

    // Running best.
    logic                        found_reg;
    logic [IDX_W-1:0]            best_idx_reg;
    logic [DIST_W-1:0]           best_d_reg;

    // Output register.
    logic                        out_valid_reg;
    logic [SLOT_W-1:0]           out_idx_reg;
    logic                        out_room_reg;
    logic [DIST_W-1:0]           out_dist_reg;

    // Decoded request fields.
    logic [SLOT_W-1:0]           in_slot;
    logic [COORD_W-1:0]          in_x, in_y, in_z;
    logic                        in_xfer;
    logic                        issue;
    logic                        drained;
    logic                        retire;

    assign in_slot = s_tdata[SLOT_W-1:0];
    assign in_x    = s_tdata[SLOT_W +: COORD_W];
    assign in_y    = s_tdata[SLOT_W + COORD_W +: COORD_W];
    assign in_z    = s_tdata[SLOT_W + 2*COORD_W +: COORD_W];

    assign n_act     = active_count(cluster_count_reg);
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && !div_busy && !div_start_reg;
    assign in_xfer   = s_tvalid && s_tready;
    assign issue     = (state_reg == ST_RUN) && (cnt_reg < n_act);
    assign drained   = !v1_reg && !v2_reg && !v3_reg && !v4_reg;
    assign retire    = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);

    // Capacity divider, restarted after every write to the cluster count or point count register.
    ccnc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (point_count_reg),
        .divisor  (n_act),
        .busy     (div_busy),
        .quotient (capacity)
    );

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cluster_count_reg <= CC_W'(1);
            point_count_reg   <= PC_W'(1);
            div_start_reg     <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_CLUSTER_COUNT: begin
                        cluster_count_reg <= cfg_data[CC_W-1:0];
                        div_start_reg     <= 1'b1;
                    end
                    CFG_POINT_COUNT: begin
                        point_count_reg <= cfg_data[PC_W-1:0];
                        div_start_reg   <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Center store, written by load requests.
    always_ff @(posedge aclk) begin
        if (in_xfer && (s_tuser == REQ_LOAD) && (int'(in_slot) < MAX_CLUSTERS)) begin
            center_mem[in_slot[IDX_W-1:0]] <= '{z: in_z, y: in_y, x: in_x};
        end
    end

    // Fill counts: cleared by a start-pass request, bumped when a point lands.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
                fill_reg[i] <= '0;
            end
        end else if (in_xfer && (s_tuser == REQ_START)) begin
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
                fill_reg[i] <= '0;
            end
        end else if (retire && found_reg) begin
            fill_reg[best_idx_reg] <= fill_reg[best_idx_reg] + FILL_W'(1);
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_xfer && (s_tuser == REQ_ASSIGN)) begin
                        state_reg <= ST_RUN;
                        cnt_reg   <= '0;
                    end
                end
                ST_RUN: begin
                    if (issue) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end else if (drained) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (retire) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Point coordinates held for the whole search.
    always_ff @(posedge aclk) begin
        if (in_xfer && (s_tuser == REQ_ASSIGN)) begin
            px_reg <= in_x;
            py_reg <= in_y;
            pz_reg <= in_z;
        end
    end

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Square terms; each product is registered before the sum.
    always_comb begin
        sqx = dx2_reg * dx2_reg;
        sqy = dy2_reg * dy2_reg;
        sqz = dz2_reg * dz2_reg;
    end

    // Datapath: read center and room, subtract, square, sum.
    always_ff @(posedge aclk) begin
        idx1_reg <= cnt_reg[IDX_W-1:0];
        el1_reg  <= fill_reg[cnt_reg[IDX_W-1:0]] < capacity;
        c1_reg   <= center_mem[cnt_reg[IDX_W-1:0]];

        idx2_reg <= idx1_reg;
        el2_reg  <= el1_reg;
        dx2_reg  <= DIFF_W'(px_reg) - DIFF_W'($signed(c1_reg.x));
        dy2_reg  <= DIFF_W'(py_reg) - DIFF_W'($signed(c1_reg.y));
        dz2_reg  <= DIFF_W'(pz_reg) - DIFF_W'($signed(c1_reg.z));

        idx3_reg <= idx2_reg;
        el3_reg  <= el2_reg;
        sx3_reg  <= SQ_W'(sqx);
        sy3_reg  <= SQ_W'(sqy);
        sz3_reg  <= SQ_W'(sqz);

        idx4_reg <= idx3_reg;
        el4_reg  <= el3_reg;
        sum4_reg <= DIST_W'(sx3_reg) + DIST_W'(sy3_reg) + DIST_W'(sz3_reg);
    end

    // Compare stage: strict less-than keeps the lower index on a tie.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            found_reg <= 1'b0;
        end else if (v4_reg && el4_reg && (!found_reg || (sum4_reg < best_d_reg))) begin
            found_reg    <= 1'b1;
            best_idx_reg <= idx4_reg;
            best_d_reg   <= sum4_reg;
        end
    end

    // Output register; a finished result waits here for the transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (retire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (retire) begin
            out_idx_reg  <= found_reg ? SLOT_W'(best_idx_reg) : '0;
            out_room_reg <= !found_reg;
            out_dist_reg <= found_reg ? best_d_reg : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - SLOT_W - DIST_W)'(0), out_dist_reg, out_idx_reg};
    assign m_tuser  = out_room_reg;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the capacity-constrained nearest center block
// Loads the centers, runs assignment passes under a range of cluster and
// point counts, and compares every result with a behavioral model of the
// nearest-center-with-room rule. Both stream sides idle at random, and the
// result side holds off once for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import ccnc_pkg::*;

    // Request code that the block ignores.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int MAX_GAP       = 6;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 300;

    localparam logic [COORD_W-1:0] COORD_MAX = 24'h7FFFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 24'h800000;

    // One expected assignment result.
    typedef struct {
        logic [IDX_W-1:0]  cluster_index;
        logic              no_room;
        logic [DIST_W-1:0] sq_distance;
    } assignment_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [REQ_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // Model state: stored centers, fill counts, registers and capacity.
    logic [COORD_W-1:0] mdl_cx   [MAX_CLUSTERS];
    logic [COORD_W-1:0] mdl_cy   [MAX_CLUSTERS];
    logic [COORD_W-1:0] mdl_cz   [MAX_CLUSTERS];
    logic [FILL_W-1:0]  mdl_fill [MAX_CLUSTERS];
    logic [CC_W-1:0]    mdl_cluster_count;
    logic [PC_W-1:0]    mdl_point_count;
    logic [FILL_W-1:0]  mdl_capacity;

    assignment_t expected_assignments[$];

    int errors;
    int requests_sent;
    int results_seen;
    int full_seen;
    int settings_run;
    bit no_idle;
    int hold_request;

    capacity_constrained_nearest_center_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog for a hung run.
    initial begin
        #3ms;
        $display("tb_top failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Model of the assignment rule
    // ------------------------------------------------------------------------

    // Number of centers searched, after clamping the programmed count.
    function automatic int clusters_in_use();
        if (mdl_cluster_count == '0) begin
            return 1;
        end
        if (int'(mdl_cluster_count) > MAX_CLUSTERS) begin
            return MAX_CLUSTERS;
        end
        return int'(mdl_cluster_count);
    endfunction

    // Squared difference along one axis of two signed coordinates.
    function automatic longint axis_sq(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
        longint da;
        longint db;
        da = longint'($signed(a));
        db = longint'($signed(b));
        return (da - db) * (da - db);
    endfunction

    // Pick the nearest center with room and take one place in it.
    task automatic nearest_open_center(input logic [COORD_W-1:0] px,
                                       input logic [COORD_W-1:0] py,
                                       input logic [COORD_W-1:0] pz,
                                       output assignment_t res);
        bit     found;
        int     best;
        int     j;
        longint best_d;
        longint d;
        found  = 1'b0;
        best   = 0;
        best_d = 0;
        for (j = 0; j < clusters_in_use(); j++) begin
            if (mdl_fill[j] >= mdl_capacity) continue;
            d = axis_sq(px, mdl_cx[j]) + axis_sq(py, mdl_cy[j]) + axis_sq(pz, mdl_cz[j]);
            if (!found || d < best_d) begin
                found  = 1'b1;
                best   = j;
                best_d = d;
            end
        end
        if (found) begin
            mdl_fill[best]    = mdl_fill[best] + FILL_W'(1);
            res.cluster_index = IDX_W'(best);
            res.no_room       = 1'b0;
            res.sq_distance   = DIST_W'(best_d);
        end else begin
            res.cluster_index = '0;
            res.no_room       = 1'b1;
            res.sq_distance   = '0;
        end
    endtask

    // Update the model for one accepted request.
    task automatic apply_request(input logic [REQ_W-1:0] req,
                                 input logic [SLOT_W-1:0] slot,
                                 input logic [COORD_W-1:0] px,
                                 input logic [COORD_W-1:0] py,
                                 input logic [COORD_W-1:0] pz);
        assignment_t res;
        case (req)
            REQ_LOAD: begin
                mdl_cx[slot] = px;
                mdl_cy[slot] = py;
                mdl_cz[slot] = pz;
            end
            REQ_START: begin
                foreach (mdl_fill[k]) mdl_fill[k] = '0;
            end
            REQ_ASSIGN: begin
                nearest_open_center(px, py, pz, res);
                expected_assignments.push_back(res);
            end
            default: begin
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one request, after a random gap unless no_idle is set, and wait for its transfer.
    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic [SLOT_W-1:0] slot,
                                input logic [COORD_W-1:0] px,
                                input logic [COORD_W-1:0] py,
                                input logic [COORD_W-1:0] pz);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata  <= {{(S_TDATA_W - SLOT_W - 3 * COORD_W){1'b0}}, pz, py, px, slot};
        s_tuser  <= req;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
        apply_request(req, slot, px, py, pz);
    endtask

    // Coordinates: mostly full range or a small box, sometimes an extreme.
    function automatic logic [COORD_W-1:0] random_coord(bit wide);
        if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
                0:       return COORD_MAX;
                1:       return COORD_MIN;
                2:       return '0;
                default: return '1;
            endcase
        end
        if (wide) begin
            return COORD_W'($urandom);
        end
        return COORD_W'($urandom_range(0, 2047) - 1024);
    endfunction

    // One request of a random kind, weighted toward assignments.
    task automatic send_random_request();
        int pick;
        bit wide;
        logic [REQ_W-1:0] req;
        pick = $urandom_range(0, 99);
        wide = 1'($urandom_range(0, 1));
        if (pick < 80) begin
            req = REQ_ASSIGN;
        end else if (pick < 92) begin
            req = REQ_LOAD;
        end else if (pick < 96) begin
            req = REQ_START;
        end else begin
            req = REQ_UNUSED;
        end
        send_request(req, SLOT_W'($urandom), random_coord(wide), random_coord(wide),
                     random_coord(wide));
    endtask

    // Stop offering, wait for every result, then let the block settle.
    task automatic idle_until_drained();
        s_tvalid <= 1'b0;
        while (expected_assignments.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One register write; valid stays high for a following write.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DAT_W-1:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == CFG_CLUSTER_COUNT) begin
            mdl_cluster_count = value[CC_W-1:0];
        end else if (idx == CFG_POINT_COUNT) begin
            mdl_point_count = value[PC_W-1:0];
        end
        mdl_capacity = FILL_W'(int'(mdl_point_count) / clusters_in_use());
    endtask

    // Write both registers while idle. Upper cluster count bits are junk.
    task automatic program_setting(input int cc, input int pc);
        idle_until_drained();
        write_register(CFG_CLUSTER_COUNT, {11'($urandom), 5'(cc)});
        write_register(CFG_POINT_COUNT, 16'(pc));
        cfg_valid <= 1'b0;
        settings_run++;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Load every center, then assign under the reset setting of one
    // cluster with room for one point, so the second point finds no room.
    task automatic test_reset_defaults();
        int s;
        send_request(REQ_LOAD, 4'd0, COORD_MAX, COORD_MAX, COORD_MAX);
        send_request(REQ_LOAD, 4'd1, COORD_MIN, COORD_MIN, COORD_MIN);
        send_request(REQ_LOAD, 4'd2, '0, '0, '0);
        send_request(REQ_LOAD, 4'd3, '0, '0, '0);
        for (s = 4; s < MAX_CLUSTERS; s++) begin
            send_request(REQ_LOAD, SLOT_W'(s), random_coord(1'b1), random_coord(1'b1),
                         random_coord(1'b1));
        end
        send_request(REQ_START, 4'd15, '0, '0, '0);
        // Farthest possible point from center zero.
        send_request(REQ_ASSIGN, 4'd0, COORD_MIN, COORD_MIN, COORD_MIN);
        send_request(REQ_ASSIGN, 4'd15, COORD_MAX, COORD_MAX, COORD_MAX);
        send_request(REQ_UNUSED, 4'd5, COORD_MAX, '0, COORD_MIN);
    endtask

    // Two equal centers tie until the lower one is full; then a point
    // count of zero leaves no room at all.
    task automatic test_ties_and_zero_capacity();
        program_setting(4, 8);
        send_request(REQ_START, 4'd0, '0, '0, '0);
        repeat (3) send_request(REQ_ASSIGN, 4'd0, '0, '0, '0);
        send_request(REQ_ASSIGN, 4'd7, COORD_MIN + COORD_W'(5), COORD_MIN,
                     COORD_MIN + COORD_W'(1));
        program_setting(4, 0);
        send_request(REQ_ASSIGN, 4'd9, '0, '0, '0);
    endtask

    // Random traffic under many settings, extremes and clamping included.
    task automatic test_random_settings();
        int phase;
        int cc;
        int pc;
        int count;
        for (phase = 0; phase < 13; phase++) begin
            count = 60;
            case (phase)
                0:  begin cc = 1;  pc = 65535; end
                1:  begin cc = 16; pc = 65535; count = 70; end
                2:  begin cc = 16; pc = 16;    count = 70; end
                3:  begin cc = 0;  pc = 3;     count = 50; end
                4:  begin cc = 31; pc = 40;    count = 70; end
                5:  begin cc = 17; pc = 100; end
                6:  begin cc = 5;  pc = 0;     count = 30; end
                7:  begin cc = 2;  pc = 7; end
                8:  begin cc = 8;  pc = 24;    count = 70; end
                9:  begin cc = 16; pc = 48;    count = 70; end
                default: begin
                    cc = $urandom_range(1, 16);
                    pc = $urandom_range(1, 64);
                end
            endcase
            program_setting(cc, pc);
            no_idle = (phase % 3 == 2);
            send_request(REQ_START, SLOT_W'($urandom), '0, '0, '0);
            repeat (count) send_random_request();
        end
        no_idle = 1'b0;
    endtask

    // The result side holds off while requests keep coming without gaps.
    task automatic test_backpressure();
        send_request(REQ_START, SLOT_W'($urandom), '0, '0, '0);
        no_idle      = 1'b1;
        hold_request = HOLD_CYCLES;
        repeat (40) send_random_request();
        no_idle = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result checker: random ready gaps, one long hold on request.
    // ------------------------------------------------------------------------
    initial begin : result_checker
        int stall;
        assignment_t want;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            results_seen++;
            if (expected_assignments.size() == 0) begin
                $error("unexpected result: cluster_index %0d no_room %0d sq_distance %0d",
                       m_tdata[IDX_W-1:0], m_tuser, m_tdata[IDX_W +: DIST_W]);
                errors++;
            end else begin
                want = expected_assignments.pop_front();
                if (want.no_room) full_seen++;
                if (m_tdata[IDX_W-1:0] !== want.cluster_index) begin
                    $error("cluster_index: expected %0d, actual %0d",
                           want.cluster_index, m_tdata[IDX_W-1:0]);
                    errors++;
                end
                if (m_tuser !== want.no_room) begin
                    $error("no_room: expected %0d, actual %0d", want.no_room, m_tuser);
                    errors++;
                end
                if (m_tdata[IDX_W +: DIST_W] !== want.sq_distance) begin
                    $error("sq_distance: expected %0d, actual %0d",
                           want.sq_distance, m_tdata[IDX_W +: DIST_W]);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;

        // Model state after reset.
        mdl_cluster_count = CC_W'(1);
        mdl_point_count   = PC_W'(1);
        mdl_capacity      = FILL_W'(1);
        foreach (mdl_fill[k]) begin
            mdl_fill[k] = '0;
            mdl_cx[k]   = '0;
            mdl_cy[k]   = '0;
            mdl_cz[k]   = '0;
        end
        errors        = 0;
        requests_sent = 0;
        results_seen  = 0;
        full_seen     = 0;
        settings_run  = 0;
        no_idle       = 1'b0;
        hold_request  = 0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_ties_and_zero_capacity();
        test_random_settings();
        test_backpressure();
        idle_until_drained();

        $display("Covered %0d requests and %0d checked results, %0d of them with no room.",
                 requests_sent, results_seen, full_seen);
        $display("Used %0d register settings, cluster counts 0 to 31, point counts 0 to 65535.",
                 settings_run);
        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

[sim.f]
design/ccnc_pkg.sv
design/ccnc_div.sv
design/capacity_constrained_nearest_center_top.sv
tb/sv/tb_top.sv
